// ===== hdl/mvrm_pkg.sv =====
// Package for the multi-voice resampling mixer: action and status codes,
// voice table entry, controller states and sample conversion helpers.
// No dependencies.
package mvrm_pkg;

  localparam int FRAC_W   = 16;
  localparam int STEP_W   = 24;
  localparam int POS_W    = 17;
  localparam int ADDR_W   = 16;
  localparam int MEM_BYTES = 65536;
  localparam int SUM_W    = 19;
  localparam int RATE_W   = 19;
  localparam int DIV_W    = 35;
  localparam int PROD_W   = 34;

  localparam logic [RATE_W-1:0] RATE_RESET = 19'd48000;
  localparam logic [STEP_W-1:0] STEP_MAX   = 24'hFFFFFF;
  localparam logic [POS_W-1:0]  POS_MAX    = 17'h1FFFF;

  localparam logic [1:0] FMT_S8  = 2'd0;
  localparam logic [1:0] FMT_U8  = 2'd1;
  localparam logic [1:0] FMT_S16 = 2'd2;
  localparam logic [1:0] FMT_S32 = 2'd3;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NO_SETUP = 2'd1;
  localparam logic [1:0] STS_RANGE    = 2'd2;

  localparam logic [1:0] VS_STOPPED = 2'd0;
  localparam logic [1:0] VS_PLAYING = 2'd1;
  localparam logic [1:0] VS_PAUSED  = 2'd2;

  typedef enum logic [2:0] {
    ACT_WRITE, ACT_SETUP, ACT_BIND, ACT_PLAY,
    ACT_PAUSE, ACT_STOP, ACT_QUERY, ACT_MIX
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DFIN, S_VOP, S_MSCAN, S_MADDR,
    S_MBYTE, S_MDRAIN, S_MMUL, S_MACC, S_DONE
  } fsm_t;

  typedef struct packed {
    logic [1:0]        fmt;
    logic [3:0]        chans;
    logic [STEP_W-1:0] step;
    logic [POS_W-1:0]  pos;
    logic [FRAC_W-1:0] frac;
    logic [ADDR_W-1:0] base;
    logic [POS_W-1:0]  len;
  } voice_t;

  function automatic logic [2:0] fmt_size(input logic [1:0] fmt);
    case (fmt)
      FMT_S16: fmt_size = 3'd2;
      FMT_S32: fmt_size = 3'd4;
      default: fmt_size = 3'd1;
    endcase
  endfunction

  // Bytes to Q1.15; for 32-bit samples the bytes passed are the upper pair.
  function automatic logic signed [15:0] to_q15(input logic [7:0] b0,
                                                input logic [7:0] b1,
                                                input logic [1:0] fmt);
    case (fmt)
      FMT_S8:  to_q15 = {b0, 8'h00};
      FMT_U8:  to_q15 = {b0 ^ 8'h80, 8'h00};
      default: to_q15 = {b1, b0};
    endcase
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] s);
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_sum = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_sum = s[SUM_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/multi_voice_resampling_mixer.sv =====
// Multi-voice resampling mixer top level: sample memory, voice table,
// shared divider and mix sequencer. Depends on mvrm_pkg.
//
// Sequence (accept to result): write, play and pause go straight to S_DONE; stop and query
// pass S_VOP; set up runs S_DIV and S_DFIN, bind S_VOP, S_DIV and S_DFIN (35-step restoring
// divider); mix runs S_MSCAN per voice and, per playing voice, S_MADDR, S_MBYTE (one sample
// memory byte read per cycle), S_MDRAIN, S_MMUL and S_MACC. One item at a time; the next
// item can be accepted in the cycle after the result is registered, later while the output
// register holds an unaccepted result. Reset (rst_n, synchronous) clears control,
// set-up and playing bits and sets output_rate to 48000; sample memory and voice
// table are not cleared (the set-up bits guard every voice table read).
module multi_voice_resampling_mixer
  import mvrm_pkg::*;
#(
  parameter int NUM_VOICES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_write_enable,
  input  logic [RATE_W-1:0]        cfg_write_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_action,
  input  logic [2:0]               in_voice_index,
  input  logic [ADDR_W-1:0]        in_address,
  input  logic [7:0]               in_byte_value,
  input  logic [1:0]               in_data_format,
  input  logic [3:0]               in_channel_count,
  input  logic [RATE_W-1:0]        in_source_rate,
  input  logic [16:0]              in_buffer_bytes,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [SUM_W-1:0]  out_left_sum,
  output logic signed [SUM_W-1:0]  out_right_sum,
  output logic [1:0]               out_voice_state
);

  localparam int VIW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [VIW-1:0] LAST_V = VIW'(NUM_VOICES - 1);

  // Configuration
  logic [RATE_W-1:0] rate_r;

  // Controller
  fsm_t state_r, state_nxt;
  action_t act_r, act_nxt;
  logic [VIW-1:0] vi_r, vi_nxt, k_r, k_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [16:0] bbytes_r, bbytes_nxt;
  logic [1:0] fmt_r, fmt_nxt;
  logic [3:0] chn_r, chn_nxt;
  logic [NUM_VOICES-1:0] set_up_r, set_up_nxt, playing_r, playing_nxt;

  // Divider
  logic [RATE_W:0]   div_rem_r, div_rem_nxt;
  logic [DIV_W-1:0]  div_quo_r, div_quo_nxt;
  logic [RATE_W-1:0] div_dvs_r, div_dvs_nxt;
  logic [5:0]        div_cnt_r, div_cnt_nxt;
  logic [RATE_W:0]   rem_sh;
  logic              rem_ge;

  // Mix datapath
  voice_t ent_r, ent_nxt;
  logic [ADDR_W-1:0] sa_r [4];
  logic [ADDR_W-1:0] sa_nxt [4];
  logic nb2_r, nb2_nxt;
  logic [2:0] rc_r, rc_nxt, cap_idx_r, cap_idx_nxt;
  logic cap_vld_r, cap_vld_nxt;
  logic [7:0] bt_r [4][2];
  logic signed [PROD_W-1:0] prod_l_r, prod_l_nxt, prod_r_r, prod_r_nxt;
  logic signed [15:0] prv_l_r, prv_l_nxt, prv_r_r, prv_r_nxt;
  logic signed [SUM_W-1:0] lsum_r, lsum_nxt, rsum_r, rsum_nxt;
  logic [1:0] res_sts_r, res_sts_nxt, res_vs_r, res_vs_nxt;

  // Output register
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_sts_r, out_sts_nxt, out_vs_r, out_vs_nxt;
  logic signed [SUM_W-1:0] out_l_r, out_l_nxt, out_r_r, out_r_nxt;

  // Memories
  voice_t vmem [NUM_VOICES];
  voice_t vmem_q, vwd;
  logic [VIW-1:0] vrd_idx, vwa;
  logic vwe;
  logic [7:0] smem [MEM_BYTES];
  logic [7:0] smem_q;
  logic [ADDR_W-1:0] smem_ra;
  logic in_xfer, smem_we;

  // Helpers
  logic [2:0] q_sz;
  logic [6:0] q_stride;
  logic [POS_W-1:0] q_prevf;
  logic [23:0] cur_prod, prv_prod;
  logic [ADDR_W-1:0] cur_a, prv_a, rch, foff;
  logic [1:0] b_sel, c_sel;
  logic b_j, c_j, b_last;
  logic signed [15:0] q_cl, q_pl, q_cr, q_pr;
  logic signed [16:0] d_l, d_r;
  logic signed [17:0] lerp_l, lerp_r;
  logic [24:0] acc;
  logic [17:0] np;
  logic [POS_W-1:0] newpos;
  logic vok;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign smem_we  = in_xfer && (action_t'(in_action) == ACT_WRITE);

  assign out_valid       = out_valid_r;
  assign out_status      = out_sts_r;
  assign out_left_sum    = out_l_r;
  assign out_right_sum   = out_r_r;
  assign out_voice_state = out_vs_r;

  assign vok = (32'(in_voice_index) < NUM_VOICES) && set_up_r[VIW'(in_voice_index)];

  // Read the addressed voice while idle, the scanned voice while mixing
  assign vrd_idx = (state_r == S_IDLE)  ? VIW'(in_voice_index) :
                   (state_r == S_MSCAN) ? k_r : vi_r;

  // Divider step: shift in one dividend bit, subtract when it fits
  assign rem_sh = {div_rem_r[RATE_W-1:0], div_quo_r[DIV_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_dvs_r};

  // Frame geometry of the entry just read
  assign q_sz     = fmt_size(vmem_q.fmt);
  assign q_stride = 7'(q_sz) * 7'(vmem_q.chans);
  assign q_prevf  = (vmem_q.pos == '0) ? '0 : vmem_q.pos - 1'b1;
  assign cur_prod = 24'(vmem_q.pos) * 24'(q_stride);
  assign prv_prod = 24'(q_prevf) * 24'(q_stride);
  assign foff     = (vmem_q.fmt == FMT_S32) ? 16'd2 : 16'd0;
  assign rch      = (vmem_q.chans > 4'd1) ? 16'(q_sz) : 16'd0;
  assign cur_a    = vmem_q.base + cur_prod[ADDR_W-1:0] + foff;
  assign prv_a    = vmem_q.base + prv_prod[ADDR_W-1:0] + foff;

  // Byte read order: sample (left cur, left prev, right cur, right prev), byte
  assign b_sel  = nb2_r ? rc_r[2:1] : rc_r[1:0];
  assign b_j    = nb2_r & rc_r[0];
  assign b_last = nb2_r ? (rc_r == 3'd7) : (rc_r == 3'd3);
  assign c_sel  = nb2_r ? cap_idx_r[2:1] : cap_idx_r[1:0];
  assign c_j    = nb2_r & cap_idx_r[0];

  assign q_cl = to_q15(bt_r[0][0], bt_r[0][1], ent_r.fmt);
  assign q_pl = to_q15(bt_r[1][0], bt_r[1][1], ent_r.fmt);
  assign q_cr = to_q15(bt_r[2][0], bt_r[2][1], ent_r.fmt);
  assign q_pr = to_q15(bt_r[3][0], bt_r[3][1], ent_r.fmt);
  assign d_l  = 17'(q_cl) - 17'(q_pl);
  assign d_r  = 17'(q_cr) - 17'(q_pr);

  // Arithmetic shift of the product floors toward minus infinity
  assign lerp_l = 18'(prv_l_r) + prod_l_r[PROD_W-1:FRAC_W];
  assign lerp_r = 18'(prv_r_r) + prod_r_r[PROD_W-1:FRAC_W];

  // Position advance: integer part of fraction + step, saturating
  assign acc    = 25'(ent_r.frac) + 25'(ent_r.step);
  assign np     = 18'(ent_r.pos) + 18'(acc[24:FRAC_W]);
  assign newpos = np[POS_W] ? POS_MAX : np[POS_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    vi_nxt      = vi_r;
    k_nxt       = k_r;
    addr_nxt    = addr_r;
    bbytes_nxt  = bbytes_r;
    fmt_nxt     = fmt_r;
    chn_nxt     = chn_r;
    set_up_nxt  = set_up_r;
    playing_nxt = playing_r;
    div_rem_nxt = div_rem_r;
    div_quo_nxt = div_quo_r;
    div_dvs_nxt = div_dvs_r;
    div_cnt_nxt = div_cnt_r;
    ent_nxt     = ent_r;
    sa_nxt      = sa_r;
    nb2_nxt     = nb2_r;
    rc_nxt      = rc_r;
    cap_vld_nxt = 1'b0;
    cap_idx_nxt = cap_idx_r;
    prod_l_nxt  = prod_l_r;
    prod_r_nxt  = prod_r_r;
    prv_l_nxt   = prv_l_r;
    prv_r_nxt   = prv_r_r;
    lsum_nxt    = lsum_r;
    rsum_nxt    = rsum_r;
    res_sts_nxt = res_sts_r;
    res_vs_nxt  = res_vs_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sts_nxt = out_sts_r;
    out_vs_nxt  = out_vs_r;
    out_l_nxt   = out_l_r;
    out_r_nxt   = out_r_r;
    vwe         = 1'b0;
    vwa         = vi_r;
    vwd         = vmem_q;
    smem_ra     = sa_r[b_sel] + 16'(b_j);

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt     = action_t'(in_action);
          vi_nxt      = VIW'(in_voice_index);
          addr_nxt    = in_address;
          bbytes_nxt  = in_buffer_bytes;
          fmt_nxt     = in_data_format;
          chn_nxt     = (in_channel_count == 4'd0) ? 4'd1 : in_channel_count;
          lsum_nxt    = '0;
          rsum_nxt    = '0;
          res_sts_nxt = STS_OK;
          res_vs_nxt  = VS_STOPPED;
          state_nxt   = S_DONE;
          case (action_t'(in_action))
            ACT_SETUP: begin
              if (32'(in_voice_index) < NUM_VOICES) begin
                div_quo_nxt = {in_source_rate, {FRAC_W{1'b0}}};
                div_rem_nxt = '0;
                div_dvs_nxt = (rate_r == '0) ? RATE_W'(1) : rate_r;
                div_cnt_nxt = '0;
                state_nxt   = S_DIV;
              end else begin
                res_sts_nxt = STS_NO_SETUP;
              end
            end
            ACT_BIND, ACT_STOP, ACT_QUERY: begin
              if (vok) state_nxt = S_VOP;
              else res_sts_nxt = STS_NO_SETUP;
            end
            ACT_PLAY: begin
              if (vok) playing_nxt[VIW'(in_voice_index)] = 1'b1;
              else res_sts_nxt = STS_NO_SETUP;
            end
            ACT_PAUSE: begin
              if (vok) playing_nxt[VIW'(in_voice_index)] = 1'b0;
              else res_sts_nxt = STS_NO_SETUP;
            end
            ACT_MIX: begin
              k_nxt     = '0;
              state_nxt = S_MSCAN;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_DIV: begin
        div_rem_nxt = rem_ge ? rem_sh - {1'b0, div_dvs_r} : rem_sh;
        div_quo_nxt = {div_quo_r[DIV_W-2:0], rem_ge};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == 6'(DIV_W - 1)) state_nxt = S_DFIN;
      end

      S_DFIN: begin
        vwe = 1'b1;
        if (act_r == ACT_SETUP) begin
          vwd.fmt   = fmt_r;
          vwd.chans = chn_r;
          vwd.step  = (|div_quo_r[DIV_W-1:STEP_W]) ? STEP_MAX : div_quo_r[STEP_W-1:0];
          vwd.pos   = '0;
          vwd.frac  = '0;
          vwd.base  = '0;
          vwd.len   = '0;
          set_up_nxt[vi_r]  = 1'b1;
          playing_nxt[vi_r] = 1'b0;
        end else begin
          vwd      = ent_r;
          vwd.base = addr_r;
          vwd.len  = div_quo_r[POS_W-1:0];
        end
        state_nxt = S_DONE;
      end

      S_VOP: begin
        ent_nxt   = vmem_q;
        state_nxt = S_DONE;
        case (act_r)
          ACT_BIND: begin
            if ((18'(addr_r) + 18'(bbytes_r)) > 18'(MEM_BYTES)) begin
              res_sts_nxt = STS_RANGE;
            end else begin
              div_quo_nxt = DIV_W'(bbytes_r);
              div_rem_nxt = '0;
              div_dvs_nxt = RATE_W'(q_stride);
              div_cnt_nxt = '0;
              state_nxt   = S_DIV;
            end
          end
          ACT_STOP: begin
            vwe      = 1'b1;
            vwd.pos  = '0;
            vwd.frac = '0;
            playing_nxt[vi_r] = 1'b0;
          end
          ACT_QUERY: begin
            if (playing_r[vi_r]) res_vs_nxt = VS_PLAYING;
            else if (vmem_q.pos == '0) res_vs_nxt = VS_STOPPED;
            else res_vs_nxt = VS_PAUSED;
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_MSCAN: begin
        // Skip silent voices; the table read of k_r lands next cycle
        if (set_up_r[k_r] && playing_r[k_r]) begin
          state_nxt = S_MADDR;
        end else if (k_r == LAST_V) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      S_MADDR: begin
        ent_nxt   = vmem_q;
        sa_nxt[0] = cur_a;
        sa_nxt[1] = prv_a;
        sa_nxt[2] = cur_a + rch;
        sa_nxt[3] = prv_a + rch;
        nb2_nxt   = vmem_q.fmt[1];
        rc_nxt    = '0;
        state_nxt = S_MBYTE;
      end

      S_MBYTE: begin
        cap_vld_nxt = 1'b1;
        cap_idx_nxt = rc_r;
        rc_nxt      = rc_r + 1'b1;
        if (b_last) state_nxt = S_MDRAIN;
      end

      S_MDRAIN: state_nxt = S_MMUL;

      S_MMUL: begin
        prod_l_nxt = d_l * $signed({1'b0, ent_r.frac});
        prod_r_nxt = d_r * $signed({1'b0, ent_r.frac});
        prv_l_nxt  = q_pl;
        prv_r_nxt  = q_pr;
        state_nxt  = S_MACC;
      end

      S_MACC: begin
        lsum_nxt = sat_sum(20'(lsum_r) + 20'(lerp_l));
        rsum_nxt = sat_sum(20'(rsum_r) + 20'(lerp_r));
        vwe      = 1'b1;
        vwa      = k_r;
        vwd      = ent_r;
        vwd.pos  = newpos;
        vwd.frac = acc[FRAC_W-1:0];
        playing_nxt[k_r] = newpos < ent_r.len;
        if (k_r == LAST_V) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_MSCAN;
        end
      end

      S_DONE: begin
        // Hold until the output register is free, then load the result
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = res_sts_r;
          out_vs_nxt    = res_vs_r;
          out_l_nxt     = lsum_r;
          out_r_nxt     = rsum_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= RATE_RESET;
      set_up_r    <= '0;
      playing_r   <= '0;
      out_valid_r <= 1'b0;
      cap_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_write_enable) rate_r <= cfg_write_data;
      set_up_r    <= set_up_nxt;
      playing_r   <= playing_nxt;
      out_valid_r <= out_valid_nxt;
      cap_vld_r   <= cap_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    vi_r      <= vi_nxt;
    k_r       <= k_nxt;
    addr_r    <= addr_nxt;
    bbytes_r  <= bbytes_nxt;
    fmt_r     <= fmt_nxt;
    chn_r     <= chn_nxt;
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    div_dvs_r <= div_dvs_nxt;
    div_cnt_r <= div_cnt_nxt;
    ent_r     <= ent_nxt;
    sa_r      <= sa_nxt;
    nb2_r     <= nb2_nxt;
    rc_r      <= rc_nxt;
    cap_idx_r <= cap_idx_nxt;
    prod_l_r  <= prod_l_nxt;
    prod_r_r  <= prod_r_nxt;
    prv_l_r   <= prv_l_nxt;
    prv_r_r   <= prv_r_nxt;
    lsum_r    <= lsum_nxt;
    rsum_r    <= rsum_nxt;
    res_sts_r <= res_sts_nxt;
    res_vs_r  <= res_vs_nxt;
    out_sts_r <= out_sts_nxt;
    out_vs_r  <= out_vs_nxt;
    out_l_r   <= out_l_nxt;
    out_r_r   <= out_r_nxt;
  end

  // Capture sample bytes in the cycle after their read
  always_ff @(posedge clk) begin
    if (cap_vld_r) bt_r[c_sel][c_j] <= smem_q;
  end

  // Voice table: one write port, registered read
  always_ff @(posedge clk) begin
    if (vwe) vmem[vwa] <= vwd;
    vmem_q <= vmem[vrd_idx];
  end

  // Sample memory: byte writes from the input channel, registered read
  always_ff @(posedge clk) begin
    if (smem_we) smem[in_address] <= in_byte_value;
    smem_q <= smem[smem_ra];
  end

  // A voice never plays without being set up
  a_play_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (playing_r & ~set_up_r) == '0)
    else $error("voice playing without set up");

  // Divider never runs past its last step
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_cnt_r < 6'(DIV_W))
    else $error("divider step count overrun");

  // Single-byte formats issue only four reads per voice
  a_byte_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MBYTE && !nb2_r) |-> rc_r < 3'd4)
    else $error("byte read count overrun");

  // An accepted transfer always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("accepted transfer not started");

endmodule

// ===== tb/sv/multi_voice_resampling_mixer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the multi-voice resampling mixer: a queued driver,
// a monitor and an in-order predictor of voices, sample memory and mixing.
// Depends on mvrm_pkg and multi_voice_resampling_mixer.
module multi_voice_resampling_mixer_test;
  import mvrm_pkg::*;

  localparam int VOICES = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    action_t     act;
    logic [2:0]  vi;
    logic [15:0] addr;
    logic [7:0]  bval;
    logic [1:0]  fmt;
    logic [3:0]  chans;
    logic [18:0] src;
    logic [16:0] bytes;
  } voice_cmd_t;

  typedef struct {
    logic [1:0]        status;
    logic [SUM_W-1:0]  left;
    logic [SUM_W-1:0]  right;
    logic [1:0]        vstate;
  } mix_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_enable = 1'b0;
  logic [RATE_W-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_action = '0;
  logic [2:0] in_voice_index = '0;
  logic [ADDR_W-1:0] in_address = '0;
  logic [7:0] in_byte_value = '0;
  logic [1:0] in_data_format = '0;
  logic [3:0] in_channel_count = '0;
  logic [RATE_W-1:0] in_source_rate = '0;
  logic [16:0] in_buffer_bytes = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [SUM_W-1:0] out_left_sum;
  logic signed [SUM_W-1:0] out_right_sum;
  logic [1:0] out_voice_state;

  voice_cmd_t  voice_cmd_q[$];
  mix_result_t mix_result_q[$];
  bit failed = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 57;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int quiet_cycles = 0;

  // Predictor state: our own copy of the memory and the voice table.
  logic [7:0] mem_img [0:65535];
  bit         mem_written [0:65535];
  logic [RATE_W-1:0] pred_rate;
  bit          v_setup [VOICES];
  bit          v_playing [VOICES];
  logic [1:0]  v_fmt [VOICES];
  logic [3:0]  v_chans [VOICES];
  logic [23:0] v_step [VOICES];
  logic [16:0] v_pos [VOICES];
  logic [15:0] v_frac [VOICES];
  logic [15:0] v_base [VOICES];
  logic [16:0] v_len [VOICES];

  always #4 clk = ~clk;

  multi_voice_resampling_mixer i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_voice_index(in_voice_index),
    .in_address(in_address), .in_byte_value(in_byte_value),
    .in_data_format(in_data_format), .in_channel_count(in_channel_count),
    .in_source_rate(in_source_rate), .in_buffer_bytes(in_buffer_bytes),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_left_sum(out_left_sum),
    .out_right_sum(out_right_sum), .out_voice_state(out_voice_state)
  );

  function automatic int bytes_per_sample(logic [1:0] f);
    return (f == FMT_S16) ? 2 : (f == FMT_S32) ? 4 : 1;
  endfunction

  // Byte address of one sample; wraps modulo the memory size.
  function automatic logic [15:0] sample_addr(int k, int frame, int ch);
    int unsigned a;
    a = v_base[k] + frame * bytes_per_sample(v_fmt[k]) * v_chans[k]
        + ch * bytes_per_sample(v_fmt[k]);
    return a[15:0];
  endfunction

  function automatic int q15_sample(int k, int frame, int ch);
    logic [15:0] a;
    logic [15:0] w;
    a = sample_addr(k, frame, ch);
    case (v_fmt[k])
      FMT_S8:  w = {mem_img[a], 8'h00};
      FMT_U8:  w = {mem_img[a] ^ 8'h80, 8'h00};
      FMT_S16: w = {mem_img[a + 16'd1], mem_img[a]};
      default: w = {mem_img[a + 16'd3], mem_img[a + 16'd2]};
    endcase
    return int'($signed(w));
  endfunction

  function automatic int lerp_channel(int k, int ch);
    longint cur, prv, prod;
    int pf;
    pf = (v_pos[k] == 0) ? 0 : int'(v_pos[k]) - 1;
    cur = q15_sample(k, v_pos[k], ch);
    prv = q15_sample(k, pf, ch);
    prod = (cur - prv) * longint'({1'b0, v_frac[k]});
    return int'(prv + (prod >>> FRAC_W));
  endfunction

  function automatic int clamp_sum(int s);
    return (s > 262143) ? 262143 : (s < -262144) ? -262144 : s;
  endfunction

  // Find a byte that the next mix would read but that was never written.
  function automatic bit unwritten_read(output logic [15:0] hole);
    logic [15:0] a;
    int rch, pf;
    for (int k = 0; k < VOICES; k++) begin
      if (v_setup[k] && v_playing[k]) begin
        rch = (v_chans[k] > 1) ? 1 : 0;
        pf = (v_pos[k] == 0) ? 0 : int'(v_pos[k]) - 1;
        for (int n = 0; n < 4; n++) begin
          a = sample_addr(k, (n < 2) ? int'(v_pos[k]) : pf, (n % 2) ? rch : 0);
          if (v_fmt[k] == FMT_S32) a = a + 16'd2;
          for (int b = 0; b < ((v_fmt[k] >= FMT_S16) ? 2 : 1); b++) begin
            if (!mem_written[a + b[15:0]]) begin
              hole = a + b[15:0];
              return 1;
            end
          end
        end
      end
    end
    return 0;
  endfunction

  // Advance the predicted block by one command and return its result.
  function automatic mix_result_t predict_mixer(voice_cmd_t c);
    mix_result_t r;
    int k, left, right;
    longint unsigned q, acc, np;
    logic [18:0] rate;
    left = 0;
    right = 0;
    k = c.vi;
    r.status = STS_OK;
    r.vstate = VS_STOPPED;
    case (c.act)
      ACT_WRITE: begin
        mem_img[c.addr] = c.bval;
        mem_written[c.addr] = 1;
      end
      ACT_SETUP: begin
        rate = (pred_rate == 0) ? 19'd1 : pred_rate;
        q = (longint'(c.src) << FRAC_W) / rate;
        v_setup[k] = 1;
        v_playing[k] = 0;
        v_fmt[k] = c.fmt;
        v_chans[k] = (c.chans == 0) ? 4'd1 : c.chans;
        v_step[k] = (q > 64'hFFFFFF) ? STEP_MAX : q[23:0];
        v_pos[k] = 0;
        v_frac[k] = 0;
        v_base[k] = 0;
        v_len[k] = 0;
      end
      ACT_MIX: begin
        for (int m = 0; m < VOICES; m++) begin
          if (v_setup[m] && v_playing[m]) begin
            left = clamp_sum(left + lerp_channel(m, 0));
            right = clamp_sum(right + lerp_channel(m, (v_chans[m] > 1) ? 1 : 0));
            acc = v_frac[m] + v_step[m];
            v_frac[m] = acc[15:0];
            np = v_pos[m] + (acc >> FRAC_W);
            v_pos[m] = (np > POS_MAX) ? POS_MAX : np[16:0];
            if (v_pos[m] >= v_len[m]) v_playing[m] = 0;
          end
        end
      end
      default: begin
        if (!v_setup[k]) begin
          r.status = STS_NO_SETUP;
        end else begin
          case (c.act)
            ACT_BIND: begin
              if (int'(c.addr) + int'(c.bytes) > MEM_BYTES) begin
                r.status = STS_RANGE;
              end else begin
                v_base[k] = c.addr;
                v_len[k] = 17'(c.bytes / (bytes_per_sample(v_fmt[k]) * v_chans[k]));
              end
            end
            ACT_PLAY:  v_playing[k] = 1;
            ACT_PAUSE: v_playing[k] = 0;
            ACT_STOP: begin
              v_playing[k] = 0;
              v_pos[k] = 0;
              v_frac[k] = 0;
            end
            default: begin
              if (v_playing[k]) r.vstate = VS_PLAYING;
              else if (v_pos[k] == 0) r.vstate = VS_STOPPED;
              else r.vstate = VS_PAUSED;
            end
          endcase
        end
      end
    endcase
    r.left = left[SUM_W-1:0];
    r.right = right[SUM_W-1:0];
    return r;
  endfunction

  // Queue one command; a mix that would read unwritten memory becomes a write
  // that fills the first such hole instead.
  task automatic issue(voice_cmd_t c);
    logic [15:0] hole;
    if (c.act == ACT_MIX && unwritten_read(hole)) begin
      c.act = ACT_WRITE;
      c.addr = hole;
    end
    mix_result_q.push_back(predict_mixer(c));
    voice_cmd_q.push_back(c);
  endtask

  function automatic voice_cmd_t random_cmd();
    voice_cmd_t c;
    int pick, hi;
    c.vi = 3'($urandom_range(0, 7));
    c.addr = 16'($urandom);
    c.bval = 8'($urandom);
    c.fmt = 2'($urandom);
    c.chans = 4'($urandom);
    c.src = 19'($urandom);
    c.bytes = 17'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c.act = ACT_WRITE;
      if ($urandom_range(0, 9) != 0) c.addr = 16'($urandom_range(0, 1023));
    end else if (pick < 40) begin
      c.act = ACT_SETUP;
      if ($urandom_range(0, 4) != 0) c.chans = 4'($urandom_range(1, 2));
      if ($urandom_range(0, 4) != 0) begin
        hi = (pred_rate == 0) ? 2 : 2 * int'(pred_rate);
        c.src = 19'($urandom_range(1, (hi > 384000) ? 384000 : hi));
      end
    end else if (pick < 50) begin
      c.act = ACT_BIND;
      if ($urandom_range(0, 5) != 0) begin
        c.addr = 16'($urandom_range(0, 768));
        c.bytes = 17'($urandom_range(0, 128));
      end
    end else if (pick < 60) c.act = ACT_PLAY;
    else if (pick < 65) c.act = ACT_PAUSE;
    else if (pick < 70) c.act = ACT_STOP;
    else if (pick < 78) c.act = ACT_QUERY;
    else c.act = ACT_MIX;
    return c;
  endfunction

  task automatic directed(action_t a, int vi, int addr, int bval, logic [1:0] f,
                          int ch, int src, int nbytes);
    voice_cmd_t c;
    c = '{a, vi[2:0], addr[15:0], bval[7:0], f, ch[3:0], src[18:0], nbytes[16:0]};
    issue(c);
  endtask

  task automatic wait_drained();
    while (voice_cmd_q.size() != 0 || mix_result_q.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: load the next command whenever the channel is free.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (voice_cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        voice_cmd_t c;
        c = voice_cmd_q.pop_front();
        in_valid <= 1'b1;
        in_action <= c.act;
        in_voice_index <= c.vi;
        in_address <= c.addr;
        in_byte_value <= c.bval;
        in_data_format <= c.fmt;
        in_channel_count <= c.chans;
        in_source_rate <= c.src;
        in_buffer_bytes <= c.bytes;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction, and
  // hold off the receiver once for a long stretch.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (mix_result_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, out_status);
        failed = 1'b1;
      end else begin
        mix_result_t e;
        e = mix_result_q.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          failed = 1'b1;
        end
        if (out_left_sum !== e.left) begin
          $display("%0t: left_sum exp %0d got %0d", $time, $signed(e.left), out_left_sum);
          failed = 1'b1;
        end
        if (out_right_sum !== e.right) begin
          $display("%0t: right_sum exp %0d got %0d", $time, $signed(e.right), out_right_sum);
          failed = 1'b1;
        end
        if (out_voice_state !== e.vstate) begin
          $display("%0t: voice_state exp %0d got %0d", $time, e.vstate, out_voice_state);
          failed = 1'b1;
        end
      end
    end
    if (!hold_done && results_seen >= 150) begin
      hold_done <= 1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int rates[6];
    rates = '{48000, 1, 384000, 0, 524287, 44100};
    pred_rate = RATE_RESET;
    for (int k = 0; k < VOICES; k++) begin
      v_setup[k] = 0; v_playing[k] = 0; v_fmt[k] = FMT_S8; v_chans[k] = 4'd1;
      v_step[k] = '0; v_pos[k] = '0; v_frac[k] = '0; v_base[k] = '0; v_len[k] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      // Idle pattern: sender light / receiver heavy, then swapped, then none.
      send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 57 : 0;
      recv_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 20 : 0;
      wait_drained();
      cfg_write_enable <= 1'b1;
      cfg_write_data <= RATE_W'(rates[ph]);
      @(posedge clk);
      cfg_write_enable <= 1'b0;
      pred_rate = RATE_W'(rates[ph]);
      if (ph == 0) begin
        directed(ACT_WRITE, 0, 0, 8'h80, FMT_S8, 1, 1, 0);
        directed(ACT_WRITE, 0, 1, 8'h7F, FMT_S8, 1, 1, 0);
        directed(ACT_WRITE, 0, 2, 8'hFF, FMT_S8, 1, 1, 0);
        directed(ACT_WRITE, 0, 3, 8'h01, FMT_S8, 1, 1, 0);
        directed(ACT_WRITE, 0, 65535, 8'h55, FMT_S8, 1, 1, 0);
        directed(ACT_QUERY, 0, 0, 0, FMT_S8, 1, 1, 0);
        directed(ACT_BIND, 7, 0, 0, FMT_S8, 1, 1, 4);
        directed(ACT_SETUP, 0, 0, 0, FMT_S8, 0, 48000, 0);
        directed(ACT_SETUP, 1, 0, 0, FMT_U8, 2, 384000, 0);
        directed(ACT_SETUP, 2, 0, 0, FMT_S16, 1, 1, 0);
        directed(ACT_SETUP, 3, 0, 0, FMT_S32, 15, 524287, 0);
        directed(ACT_BIND, 0, 65535, 0, FMT_S8, 1, 1, 2);
        directed(ACT_BIND, 0, 0, 0, FMT_S8, 1, 1, 4);
        directed(ACT_BIND, 1, 0, 0, FMT_S8, 1, 1, 65536);
        directed(ACT_BIND, 2, 0, 0, FMT_S8, 1, 1, 4);
        directed(ACT_BIND, 3, 0, 0, FMT_S8, 1, 1, 0);
        for (int k = 0; k < 4; k++) directed(ACT_PLAY, k, 0, 0, FMT_S8, 1, 1, 0);
        directed(ACT_MIX, 0, 0, 0, FMT_S8, 1, 1, 0);
        directed(ACT_QUERY, 0, 0, 0, FMT_S8, 1, 1, 0);
        directed(ACT_PAUSE, 1, 0, 0, FMT_S8, 1, 1, 0);
        directed(ACT_QUERY, 1, 0, 0, FMT_S8, 1, 1, 0);
        directed(ACT_STOP, 2, 0, 0, FMT_S8, 1, 1, 0);
        directed(ACT_MIX, 0, 0, 0, FMT_S8, 1, 1, 0);
      end
      for (int n = 0; n < 100; n++) issue(random_cmd());
    end
    wait_drained();
    if (!failed && mix_result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
